// ----- rtl/core/tap_pkg.sv -----
// Shared types and constants for the tensor axis permute address generator.
package tap_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int SIZE_W     = 9;
    localparam int SIZE_REGS  = 4;
    localparam int PERM_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int OFFSET_W   = 32;
    localparam int ELEM_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_AXES   = 3'd0,
        CFG_AXIS0_SIZE = 3'd1,
        CFG_AXIS1_SIZE = 3'd2,
        CFG_AXIS2_SIZE = 3'd3,
        CFG_AXIS3_SIZE = 3'd4,
        CFG_PERM_MAP   = 3'd5
    } tap_cfg_idx_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_STRIDE,
        SEQ_PRODUCT
    } tap_seq_t;

    typedef struct packed {
        logic               busy;
        logic               perm_ok;
        logic [COUNT_W-1:0] used_axes;
    } tap_ctrl_t;

endpackage

// ----- rtl/core/tap_cfg.sv -----
// Configuration registers and the stride and partial-offset setup sequencer.
module tap_cfg #(
    parameter int MAX_AXES  = 4,
    parameter int AXIS_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tap_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [tap_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic [AXIS_BITS-1:0]               axis_index [MAX_AXES],
    output tap_pkg::tap_ctrl_t                 ctrl,
    output logic [tap_pkg::SIZE_W-1:0]         eff_size [MAX_AXES],
    output logic [tap_pkg::OFFSET_W-1:0]       stride [MAX_AXES],
    output logic [MAX_AXES-1:0]                prod_we,
    output logic [tap_pkg::OFFSET_W-1:0]       prod_value
);

    localparam int STEP_W   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_AXES - 1);
    localparam int SIZE_LIM = ((1 << AXIS_BITS) < 256) ? (1 << AXIS_BITS) : 256;
    localparam int ACC_PW   = tap_pkg::OFFSET_W + tap_pkg::SIZE_W;
    localparam int PROD_PW  = tap_pkg::OFFSET_W + AXIS_BITS;

    logic [2:0]                        num_axes_reg;
    logic [tap_pkg::SIZE_W-1:0]        size_reg [tap_pkg::SIZE_REGS];
    logic [tap_pkg::PERM_W-1:0]        perm_map_reg;

    tap_pkg::tap_seq_t                 state_reg, state_next;
    logic [STEP_W-1:0]                 step_reg;
    logic [tap_pkg::OFFSET_W-1:0]      acc_reg;
    logic [tap_pkg::OFFSET_W-1:0]      stride_reg [MAX_AXES];

    logic [tap_pkg::COUNT_W-1:0]       used_axes;
    logic [tap_pkg::COUNT_W-1:0]       perm_entry [MAX_AXES];
    logic                              perm_ok;
    logic                              busy;
    logic                              stride_we;
    logic                              prod_en;
    logic [STEP_W-1:0]                 perm_sel;
    logic [ACC_PW-1:0]                 acc_prod;
    logic [PROD_PW-1:0]                prod_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_axes_reg <= 3'd2;
            for (int i = 0; i < tap_pkg::SIZE_REGS; i++) begin
                size_reg[i] <= tap_pkg::SIZE_W'(1);
            end
            perm_map_reg <= 8'd228;
        end else if (cfg_wr_en) begin
            unique case (tap_pkg::tap_cfg_idx_t'(cfg_wr_index))
                tap_pkg::CFG_NUM_AXES:   num_axes_reg <= cfg_wr_data[2:0];
                tap_pkg::CFG_AXIS0_SIZE: size_reg[0]  <= cfg_wr_data;
                tap_pkg::CFG_AXIS1_SIZE: size_reg[1]  <= cfg_wr_data;
                tap_pkg::CFG_AXIS2_SIZE: size_reg[2]  <= cfg_wr_data;
                tap_pkg::CFG_AXIS3_SIZE: size_reg[3]  <= cfg_wr_data;
                tap_pkg::CFG_PERM_MAP:   perm_map_reg <= cfg_wr_data[tap_pkg::PERM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        used_axes = {1'b0, num_axes_reg};
        if (used_axes == '0) begin
            used_axes = tap_pkg::COUNT_W'(1);
        end else if (used_axes > tap_pkg::COUNT_W'(MAX_AXES)) begin
            used_axes = tap_pkg::COUNT_W'(MAX_AXES);
        end
    end

    // Axes without a size register act as size one; result axes beyond the
    // permutation field take the source axis of their own number.
    for (genvar s = 0; s < MAX_AXES; s++) begin : g_axis
        if (s < tap_pkg::SIZE_REGS) begin : g_sized
            always_comb begin
                eff_size[s] = size_reg[s];
                if (eff_size[s] == '0) begin
                    eff_size[s] = tap_pkg::SIZE_W'(1);
                end else if (eff_size[s] > tap_pkg::SIZE_W'(SIZE_LIM)) begin
                    eff_size[s] = tap_pkg::SIZE_W'(SIZE_LIM);
                end
            end
            assign perm_entry[s] = {2'b00, perm_map_reg[2*s +: 2]};
        end else begin : g_unsized
            assign eff_size[s]   = tap_pkg::SIZE_W'(1);
            assign perm_entry[s] = tap_pkg::COUNT_W'(s);
        end
    end

    always_comb begin
        perm_ok = 1'b1;
        for (int i = 0; i < MAX_AXES; i++) begin
            if (tap_pkg::COUNT_W'(i) < used_axes) begin
                if (perm_entry[i] >= used_axes) begin
                    perm_ok = 1'b0;
                end
                for (int j = 0; j < i; j++) begin
                    if (perm_entry[j] == perm_entry[i]) begin
                        perm_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tap_pkg::SEQ_IDLE:    state_next = tap_pkg::SEQ_IDLE;
            tap_pkg::SEQ_STRIDE:  if (step_reg == '0) state_next = tap_pkg::SEQ_PRODUCT;
            tap_pkg::SEQ_PRODUCT: if (step_reg == '0) state_next = tap_pkg::SEQ_IDLE;
            default:              state_next = tap_pkg::SEQ_IDLE;
        endcase
        if (cfg_wr_en) begin
            state_next = tap_pkg::SEQ_STRIDE;
        end
    end

    always_comb begin
        busy      = (state_reg != tap_pkg::SEQ_IDLE);
        stride_we = (state_reg == tap_pkg::SEQ_STRIDE) && perm_ok &&
                    (tap_pkg::COUNT_W'(step_reg) < used_axes);
        prod_en   = (state_reg == tap_pkg::SEQ_PRODUCT);
    end

    // The stride pass walks result axes from the fastest one up, so the
    // accumulator holds the product of the extents already placed.
    assign perm_sel  = perm_entry[step_reg][STEP_W-1:0];
    assign acc_prod  = acc_reg * eff_size[perm_sel];
    assign prod_full = axis_index[step_reg] * stride_reg[step_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tap_pkg::SEQ_STRIDE;
            step_reg  <= LAST_STEP;
            acc_reg   <= tap_pkg::OFFSET_W'(1);
            for (int i = 0; i < MAX_AXES; i++) begin
                stride_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                step_reg <= LAST_STEP;
                acc_reg  <= tap_pkg::OFFSET_W'(1);
                for (int i = 0; i < MAX_AXES; i++) begin
                    stride_reg[i] <= '0;
                end
            end else if (busy) begin
                step_reg <= (step_reg == '0) ? LAST_STEP : step_reg - 1'b1;
                if (stride_we) begin
                    stride_reg[perm_sel] <= acc_reg;
                    acc_reg              <= acc_prod[tap_pkg::OFFSET_W-1:0];
                end
            end
        end
    end

    assign prod_we    = prod_en ? (MAX_AXES'(1) << step_reg) : '0;
    assign prod_value = prod_full[tap_pkg::OFFSET_W-1:0];
    assign stride     = stride_reg;

    assign ctrl.busy      = busy;
    assign ctrl.perm_ok   = perm_ok;
    assign ctrl.used_axes = used_axes;

endmodule

// ----- rtl/core/tap_core.sv -----
// Per-axis index counters, running destination offset and the result register.
module tap_core #(
    parameter int MAX_AXES     = 4,
    parameter int AXIS_BITS    = 8,
    parameter int ELEMENT_BITS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tap_pkg::ELEM_W-1:0]        s_element_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tap_pkg::OFFSET_W-1:0]      m_dest_offset,
    output logic [tap_pkg::ELEM_W-1:0]        m_element_out,
    output logic                              m_last_element,
    output logic                              m_perm_error,
    input  tap_pkg::tap_ctrl_t                ctrl,
    input  logic [tap_pkg::SIZE_W-1:0]        eff_size [MAX_AXES],
    input  logic [tap_pkg::OFFSET_W-1:0]      stride [MAX_AXES],
    input  logic [MAX_AXES-1:0]               prod_we,
    input  logic [tap_pkg::OFFSET_W-1:0]      prod_value,
    output logic [AXIS_BITS-1:0]              axis_index [MAX_AXES]
);

    localparam int CMP_W = ((AXIS_BITS > tap_pkg::SIZE_W) ? AXIS_BITS : tap_pkg::SIZE_W) + 1;
    localparam logic [tap_pkg::ELEM_W-1:0] ELEM_MASK =
        {tap_pkg::ELEM_W{1'b1}} >> (tap_pkg::ELEM_W - ELEMENT_BITS);

    logic [AXIS_BITS-1:0]          idx_reg  [MAX_AXES];
    logic [AXIS_BITS-1:0]          idx_next [MAX_AXES];
    logic [tap_pkg::OFFSET_W-1:0]  prod_reg  [MAX_AXES];
    logic [tap_pkg::OFFSET_W-1:0]  prod_next [MAX_AXES];
    logic [tap_pkg::OFFSET_W-1:0]  dest_reg, dest_next;

    logic                          m_valid_reg, m_valid_next;
    logic [tap_pkg::OFFSET_W-1:0]  m_dest_reg;
    logic [tap_pkg::ELEM_W-1:0]    m_elem_reg;
    logic                          m_last_reg;
    logic                          m_err_reg;

    logic                          fire;
    logic [MAX_AXES-1:0]           used, can_inc, at_last, incr, clr;
    logic                          last;
    logic                          carry;
    logic [tap_pkg::OFFSET_W-1:0]  sub_sum, add_val, dest_step;

    assign fire    = s_valid && s_ready;
    assign s_ready = !ctrl.busy && (!m_valid_reg || m_ready);

    always_comb begin
        for (int s = 0; s < MAX_AXES; s++) begin
            used[s]    = tap_pkg::COUNT_W'(s) < ctrl.used_axes;
            can_inc[s] = (CMP_W'(idx_reg[s]) + 1'b1) <  CMP_W'(eff_size[s]);
            at_last[s] = (CMP_W'(idx_reg[s]) + 1'b1) == CMP_W'(eff_size[s]);
        end
        last = 1'b1;
        for (int s = 0; s < MAX_AXES; s++) begin
            if (used[s] && !at_last[s]) begin
                last = 1'b0;
            end
        end
        // Carry ripples from the fastest used axis toward axis 0 and stops
        // at the first axis that can still count up.
        carry = 1'b1;
        for (int s = MAX_AXES - 1; s >= 0; s--) begin
            incr[s] = used[s] && carry && can_inc[s];
            clr[s]  = used[s] && carry && !can_inc[s];
            if (used[s]) begin
                carry = carry && !can_inc[s];
            end
        end
    end

    always_comb begin
        sub_sum = '0;
        add_val = '0;
        for (int s = 0; s < MAX_AXES; s++) begin
            if (clr[s]) begin
                sub_sum = sub_sum + prod_reg[s];
            end
            if (incr[s]) begin
                add_val = add_val | stride[s];
            end
        end
        dest_step = dest_reg - sub_sum + add_val;
    end

    always_comb begin
        for (int s = 0; s < MAX_AXES; s++) begin
            idx_next[s]  = idx_reg[s];
            prod_next[s] = prod_reg[s];
            if (last || clr[s]) begin
                idx_next[s]  = '0;
                prod_next[s] = '0;
            end else if (incr[s]) begin
                idx_next[s]  = idx_reg[s] + 1'b1;
                prod_next[s] = prod_reg[s] + stride[s];
            end
        end
        dest_next = (last || !ctrl.perm_ok) ? '0 : dest_step;
    end

    assign m_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            dest_reg    <= '0;
            for (int s = 0; s < MAX_AXES; s++) begin
                idx_reg[s]  <= '0;
                prod_reg[s] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                dest_reg <= dest_next;
            end
            for (int s = 0; s < MAX_AXES; s++) begin
                if (prod_we[s]) begin
                    prod_reg[s] <= prod_value;
                end else if (fire) begin
                    prod_reg[s] <= prod_next[s];
                end
                if (fire) begin
                    idx_reg[s] <= idx_next[s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_dest_reg <= ctrl.perm_ok ? dest_reg : '0;
            m_elem_reg <= s_element_in & ELEM_MASK;
            m_last_reg <= last;
            m_err_reg  <= !ctrl.perm_ok;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_dest_offset  = m_dest_reg;
    assign m_element_out  = m_elem_reg;
    assign m_last_element = m_last_reg;
    assign m_perm_error   = m_err_reg;
    assign axis_index     = idx_reg;

endmodule

// ----- rtl/core/tensor_axis_permute_address.sv -----
// A beat accepted at a clock edge appears on the result port in the following cycle;
// the index carry and offset add are combinational. Throughput: one beat per cycle
// while no setup pass runs and no result waits on m_ready. After reset and after every
// configuration write, a setup pass computes the strides and per-axis partial offsets;
// s_ready is low during it. Reset returns the registers to two axes of size one with the
// identity order, and clears the index counters and the running offset.
module tensor_axis_permute_address #(
    parameter int MAX_AXES     = 4,
    parameter int ELEMENT_BITS = 64,
    parameter int AXIS_BITS    = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tap_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [tap_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tap_pkg::ELEM_W-1:0]        s_element_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tap_pkg::OFFSET_W-1:0]      m_dest_offset,
    output logic [tap_pkg::ELEM_W-1:0]        m_element_out,
    output logic                              m_last_element,
    output logic                              m_perm_error
);

    tap_pkg::tap_ctrl_t               ctrl;
    logic [tap_pkg::SIZE_W-1:0]       eff_size [MAX_AXES];
    logic [tap_pkg::OFFSET_W-1:0]     stride [MAX_AXES];
    logic [MAX_AXES-1:0]              prod_we;
    logic [tap_pkg::OFFSET_W-1:0]     prod_value;
    logic [AXIS_BITS-1:0]             axis_index [MAX_AXES];

    tap_cfg #(
        .MAX_AXES  (MAX_AXES),
        .AXIS_BITS (AXIS_BITS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .axis_index   (axis_index),
        .ctrl         (ctrl),
        .eff_size     (eff_size),
        .stride       (stride),
        .prod_we      (prod_we),
        .prod_value   (prod_value)
    );

    tap_core #(
        .MAX_AXES     (MAX_AXES),
        .AXIS_BITS    (AXIS_BITS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element_in   (s_element_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest_offset  (m_dest_offset),
        .m_element_out  (m_element_out),
        .m_last_element (m_last_element),
        .m_perm_error   (m_perm_error),
        .ctrl           (ctrl),
        .eff_size       (eff_size),
        .stride         (stride),
        .prod_we        (prod_we),
        .prod_value     (prod_value),
        .axis_index     (axis_index)
    );

    // No beat may enter while strides or partial offsets are being rebuilt.
    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.busy |-> !s_ready)
        else $error("input accepted during setup pass");

    a_write_starts_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("configuration write did not start a setup pass");

    a_error_zero_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_perm_error) |-> (m_dest_offset == '0))
        else $error("nonzero offset reported with a permutation error");

endmodule

// ----- test/tensor_axis_permute_address_checker.sv -----
// Checker for the tensor axis permute address generator: predicts each result beat and compares.
`timescale 1ns / 1ps
module tensor_axis_permute_address_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tap_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [tap_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [tap_pkg::ELEM_W-1:0]     s_element_in,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [tap_pkg::OFFSET_W-1:0]   m_dest_offset,
    input  logic [tap_pkg::ELEM_W-1:0]     m_element_out,
    input  logic                           m_last_element,
    input  logic                           m_perm_error,
    output int                             error_count,
    output int                             pending_count,
    output int                             tensor_count,
    output int                             bad_perm_count
);
    import tap_pkg::*;

    localparam int AXES = 4;

    typedef struct packed {
        logic [OFFSET_W-1:0] dest_offset;
        logic [ELEM_W-1:0]   element;
        logic                last_element;
        logic                perm_error;
    } placement_t;

    placement_t placements_due[$];

    // Shadow of the configuration registers.
    logic [2:0]        axes_reg;
    logic [SIZE_W-1:0] size_reg [SIZE_REGS];
    logic [PERM_W-1:0] perm_reg;

    // Shadow of the index counters and the running destination offset.
    logic [7:0]          axis_pos [AXES];
    logic [OFFSET_W-1:0] dest_pos;

    int mismatches = 0;
    int tensors    = 0;
    int bad_perm   = 0;

    function automatic int unsigned axes_in_use();
        int unsigned n;
        n = 32'(axes_reg);
        if (n < 1) n = 1;
        if (n > AXES) n = AXES;
        return n;
    endfunction

    function automatic int unsigned extent(input int unsigned axis);
        int unsigned v;
        v = 32'(size_reg[axis]);
        if (v == 0) v = 1;
        if (v > 256) v = 256;
        return v;
    endfunction

    task automatic place_element(input logic [ELEM_W-1:0] elem);
        int unsigned n, acc, d, i, s;
        int unsigned src [AXES];
        int unsigned stride [AXES];
        bit seen [AXES];
        bit ok, last, carried;
        placement_t beat;
        n = axes_in_use();
        ok = 1'b1;
        for (i = 0; i < AXES; i++) begin
            seen[i] = 1'b0;
            stride[i] = 0;
        end
        for (i = 0; i < n; i++) begin
            src[i] = (perm_reg >> (2 * i)) & 3;
            if (src[i] >= n || seen[src[i]]) ok = 1'b0;
            else seen[src[i]] = 1'b1;
        end
        // The stride of a source axis is the product of the result extents to its right.
        if (ok) begin
            acc = 1;
            for (i = n; i > 0; i--) begin
                stride[src[i-1]] = acc;
                acc = acc * extent(src[i-1]);
            end
        end

        last = 1'b1;
        for (s = 0; s < n; s++)
            if (axis_pos[s] != extent(s) - 1) last = 1'b0;

        beat.dest_offset  = ok ? dest_pos : '0;
        beat.element      = elem;
        beat.last_element = last;
        beat.perm_error   = !ok;
        placements_due.push_back(beat);

        if (last) begin
            for (s = 0; s < AXES; s++) axis_pos[s] = '0;
            dest_pos = '0;
        end else begin
            // Counters at or past their extent (after a size change) carry as well.
            d = dest_pos;
            carried = 1'b1;
            for (s = n; s > 0 && carried; s--) begin
                if (axis_pos[s-1] + 1 < extent(s-1)) begin
                    axis_pos[s-1] = axis_pos[s-1] + 1'b1;
                    d = d + stride[s-1];
                    carried = 1'b0;
                end else begin
                    d = d - axis_pos[s-1] * stride[s-1];
                    axis_pos[s-1] = '0;
                end
            end
            dest_pos = ok ? d : '0;
        end
    endtask

    task automatic flag_field(input string field, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endtask

    task automatic check_result();
        placement_t want;
        if (placements_due.size() == 0) begin
            mismatches++;
            $error("result beat with no element outstanding: dest_offset 0x%0h",
                   m_dest_offset);
        end else begin
            want = placements_due.pop_front();
            if (want.last_element) tensors++;
            if (want.perm_error) bad_perm++;
            if (m_dest_offset !== want.dest_offset)
                flag_field("dest_offset", want.dest_offset, m_dest_offset);
            if (m_element_out !== want.element)
                flag_field("element_out", want.element, m_element_out);
            if (m_last_element !== want.last_element)
                flag_field("last_element", want.last_element, m_last_element);
            if (m_perm_error !== want.perm_error)
                flag_field("perm_error", want.perm_error, m_perm_error);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            axes_reg = 3'd2;
            for (int k = 0; k < SIZE_REGS; k++) size_reg[k] = 9'd1;
            perm_reg = 8'd228;
            for (int k = 0; k < AXES; k++) axis_pos[k] = '0;
            dest_pos = '0;
            placements_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_NUM_AXES:   axes_reg = cfg_wr_data[2:0];
                    CFG_AXIS0_SIZE: size_reg[0] = cfg_wr_data;
                    CFG_AXIS1_SIZE: size_reg[1] = cfg_wr_data;
                    CFG_AXIS2_SIZE: size_reg[2] = cfg_wr_data;
                    CFG_AXIS3_SIZE: size_reg[3] = cfg_wr_data;
                    CFG_PERM_MAP:   perm_reg = cfg_wr_data[PERM_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) place_element(s_element_in);
            if (m_valid && m_ready) check_result();
        end
        error_count    <= mismatches;
        pending_count  <= placements_due.size();
        tensor_count   <= tensors;
        bad_perm_count <= bad_perm;
    end

endmodule

// ----- test/tensor_axis_permute_address_test.sv -----
// Testbench top for the tensor axis permute address generator: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tensor_axis_permute_address_test;
    import tap_pkg::*;

    localparam int BEAT_TARGET = 1900;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TENSOR_CAP  = 300;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [ELEM_W-1:0]     s_element_in = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [OFFSET_W-1:0]   m_dest_offset;
    logic [ELEM_W-1:0]     m_element_out;
    logic                  m_last_element;
    logic                  m_perm_error;

    int error_count, pending_count, tensor_count, bad_perm_count;
    int beats_sent     = 0;
    int phases         = 0;
    int cycle_count    = 0;
    int tx_max_gap     = 14;
    int rx_max_gap     = 14;
    int rx_hold_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tensor_axis_permute_address DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element_in   (s_element_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest_offset  (m_dest_offset),
        .m_element_out  (m_element_out),
        .m_last_element (m_last_element),
        .m_perm_error   (m_perm_error)
    );

    tensor_axis_permute_address_checker placement_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element_in   (s_element_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dest_offset  (m_dest_offset),
        .m_element_out  (m_element_out),
        .m_last_element (m_last_element),
        .m_perm_error   (m_perm_error),
        .error_count    (error_count),
        .pending_count  (pending_count),
        .tensor_count   (tensor_count),
        .bad_perm_count (bad_perm_count)
    );

    function automatic int unsigned extent_of(input int unsigned raw);
        if (raw == 0) return 1;
        if (raw > 256) return 256;
        return raw;
    endfunction

    // The enable stays high across back-to-back writes; load_config lowers it.
    task automatic write_reg(input tap_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [8:0] axes_word, input logic [8:0] s0,
                               input logic [8:0] s1, input logic [8:0] s2,
                               input logic [8:0] s3, input logic [8:0] perm_word);
        write_reg(CFG_NUM_AXES, axes_word);
        write_reg(CFG_AXIS0_SIZE, s0);
        write_reg(CFG_AXIS1_SIZE, s1);
        write_reg(CFG_AXIS2_SIZE, s2);
        write_reg(CFG_AXIS3_SIZE, s3);
        write_reg(CFG_PERM_MAP, perm_word);
        cfg_wr_en <= 1'b0;
        phases++;
    endtask

    task automatic send_element(input logic [ELEM_W-1:0] data);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_element_in <= data;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_element({$urandom, $urandom});
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : receiver
        int stall, hold;
        while (!aresetn) @(posedge aclk);
        forever begin
            // A long hold-off lets the block fill and push back on its input.
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            stall = $urandom_range(0, rx_max_gap);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : stimulus
        int unsigned n_use, total, count;
        int r, a, j, big, tmp;
        logic [8:0] axes_word, perm_word;
        logic [8:0] sz [4];
        int order [4];

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: every element is a whole tensor.
        send_element('0);
        send_element('1);
        wait_drained();

        // An axis count of zero acts as one; entries of unused result axes are ignored.
        load_config(9'h100, 9'd3, 9'd0, 9'd7, 9'd1, 9'h0FC);
        send_random(3);
        wait_drained();

        // An axis count above the maximum, a zero size and a fully reversed order.
        load_config(9'h1FF, 9'd2, 9'd0, 9'd2, 9'd1, 9'h11B);
        send_element(64'hAAAA_AAAA_AAAA_AAAA);
        send_element(64'h5555_5555_5555_5555);
        send_random(2);
        wait_drained();

        // A map that names one source axis more than once is not a permutation.
        load_config(9'd3, 9'd2, 9'd2, 9'd1, 9'd0, 9'h000);
        send_random(4);
        wait_drained();

        // Swapped 3x3 stopped mid-tensor, then shrunk so that an index lies past its extent.
        load_config(9'd2, 9'd3, 9'd3, 9'd0, 9'd0, 9'h0F1);
        send_random(6);
        wait_drained();
        load_config(9'd2, 9'd2, 9'd2, 9'd5, 9'd9, 9'h1F1);
        send_random(2);
        wait_drained();

        // An oversize extent saturates, then the all-ones map is invalid for one axis.
        load_config(9'd1, 9'd511, 9'd256, 9'd1, 9'd1, 9'h1FC);
        send_random(3);
        wait_drained();
        load_config(9'h1F9, 9'd2, 9'd1, 9'd1, 9'd1, 9'h0FF);
        send_random(2);
        wait_drained();

        while (beats_sent < BEAT_TARGET) begin
            r = $urandom_range(0, 9);
            if (r == 0) tmp = $urandom_range(0, 1) ? 0 : $urandom_range(5, 7);
            else tmp = $urandom_range(1, 4);
            n_use = (tmp < 1) ? 1 : (tmp > 4) ? 4 : tmp;
            axes_word = 9'($urandom);
            axes_word[2:0] = tmp[2:0];

            for (a = 0; a < 4; a++) begin
                if (a >= n_use) sz[a] = 9'($urandom);
                else if ($urandom_range(0, 19) == 0) sz[a] = '0;
                else sz[a] = 9'($urandom_range(1, (n_use >= 3) ? 4 : 9));
            end
            if ($urandom_range(0, 11) == 0) begin
                big = $urandom_range(0, n_use - 1);
                for (a = 0; a < n_use; a++) sz[a] = 9'd1;
                sz[big] = 9'($urandom_range(200, 511));
            end

            for (a = 0; a < 4; a++) order[a] = a;
            for (a = n_use - 1; a > 0; a--) begin
                j = $urandom_range(0, a);
                tmp = order[a];
                order[a] = order[j];
                order[j] = tmp;
            end
            perm_word = 9'($urandom);
            if ($urandom_range(0, 4) != 0)
                for (a = 0; a < n_use; a++) perm_word[2*a +: 2] = 2'(order[a]);

            total = 1;
            for (a = 0; a < n_use; a++) total = total * extent_of(32'(sz[a]));
            r = $urandom_range(0, 9);
            if (r <= 6 && total <= TENSOR_CAP) count = total;
            else if (r == 7 && total <= TENSOR_CAP / 2) count = 2 * total;
            else count = $urandom_range(1, (total > TENSOR_CAP) ? TENSOR_CAP : total);

            tx_max_gap = $urandom_range(0, 2) ? 14 : 0;
            rx_max_gap = $urandom_range(0, 2) ? 14 : 0;

            load_config(axes_word, sz[0], sz[1], sz[2], sz[3], perm_word);
            if (phases % 25 == 10) begin
                tx_max_gap = 0;
                rx_hold_cycles = 200;
                count = count + 30;
            end
            send_random(count);
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        $display("Summary: %0d element beats under %0d configurations, %0d tensors completed,",
                 beats_sent, phases, tensor_count);
        $display("         %0d beats carried a map that was not a permutation.", bad_perm_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
